[rtl/nir_pkg.sv]
`timescale 1ns / 1ps

package nir_pkg;

  // Action codes carried by an input item.
  typedef enum logic [1:0] {
    ACT_EDGE  = 2'd0,
    ACT_OVF   = 2'd1,
    ACT_FETCH = 2'd2
  } act_t;

  // Receiver phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LPULSE = 3'd1,
    PH_LSPACE = 3'd2,
    PH_MARK   = 3'd3,
    PH_SPACE  = 3'd4
  } phase_t;

  localparam int unsigned CMD_W      = 16;
  localparam int unsigned IVL_W      = 8;
  localparam int unsigned REG_W      = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_LP_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LP_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LS_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LS_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MARK_MIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MARK_MAX = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPC_MAX  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ONE_THR  = 3'd7;

  localparam logic [REG_W-1:0] RST_LP_MIN   = 8'd132;
  localparam logic [REG_W-1:0] RST_LP_MAX   = 8'd148;
  localparam logic [REG_W-1:0] RST_LS_MIN   = 8'd62;
  localparam logic [REG_W-1:0] RST_LS_MAX   = 8'd78;
  localparam logic [REG_W-1:0] RST_MARK_MIN = 8'd6;
  localparam logic [REG_W-1:0] RST_MARK_MAX = 8'd10;
  localparam logic [REG_W-1:0] RST_SPC_MAX  = 8'd28;
  localparam logic [REG_W-1:0] RST_ONE_THR  = 8'd15;

  typedef struct packed {
    logic [REG_W-1:0] lp_min;
    logic [REG_W-1:0] lp_max;
    logic [REG_W-1:0] ls_min;
    logic [REG_W-1:0] ls_max;
    logic [REG_W-1:0] mark_min;
    logic [REG_W-1:0] mark_max;
    logic [REG_W-1:0] space_max;
    logic [REG_W-1:0] one_thr;
  } cfg_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    act_t act;
    logic lp_ok;
    logic ls_ok;
    logic mark_ok;
    logic space_ok;
    logic bit_one;
  } token_t;

  typedef struct packed {
    logic             code_valid;
    logic [CMD_W-1:0] command;
    logic             busy;
  } res_t;

endpackage

[rtl/nir_fifo.sv]
`timescale 1ns / 1ps

module nir_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/nir_front.sv]
`timescale 1ns / 1ps

module nir_front (
  input  logic [1:0]                 in_action,
  input  logic [nir_pkg::IVL_W-1:0]  in_interval,
  input  nir_pkg::cfg_t              cfg,
  output nir_pkg::token_t            tok
);

  import nir_pkg::*;

  // Every window is checked up front; the back end picks the one its phase needs.
  always_comb begin
    tok.act      = act_t'(in_action);
    tok.lp_ok    = (in_interval >= cfg.lp_min) && (in_interval <= cfg.lp_max);
    tok.ls_ok    = (in_interval >= cfg.ls_min) && (in_interval <= cfg.ls_max);
    tok.mark_ok  = (in_interval >= cfg.mark_min) && (in_interval <= cfg.mark_max);
    tok.space_ok = (in_interval >= cfg.mark_min) && (in_interval <= cfg.space_max);
    tok.bit_one  = (in_interval > cfg.one_thr);
  end

endmodule

[rtl/nir_back.sv]
`timescale 1ns / 1ps

module nir_back #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_empty,
  input  nir_pkg::token_t tok,
  output logic            tok_pop,
  input  logic            res_full,
  output logic            res_push,
  output nir_pkg::res_t   res
);

  import nir_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_BITS + 1);

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CODE_BITS-1:0]   code_r, code_nxt;
  logic                   ready_r, ready_nxt;
  logic [CMD_W-1:0]       upper;

  generate
    if (CODE_BITS >= CMD_W) begin : g_wide
      assign upper = code_r[CODE_BITS-1 -: CMD_W];
    end else begin : g_narrow
      assign upper = {code_r, {(CMD_W - CODE_BITS){1'b0}}};
    end
  endgenerate

  // Bits arrive MSB first, so shifting in from the right leaves the complete
  // code in place once the last bit lands.
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    code_nxt       = code_r;
    ready_nxt      = ready_r;
    res.code_valid = 1'b0;
    res.command    = '0;
    tok_pop        = !tok_empty && !res_full;
    res_push       = tok_pop;
    if (tok_pop) begin
      unique case (tok.act)
        ACT_EDGE: begin
          if (!ready_r) begin
            unique case (phase_r)
              PH_IDLE: begin
                phase_nxt = PH_LPULSE;
                cnt_nxt   = '0;
              end
              PH_LPULSE: phase_nxt = tok.lp_ok ? PH_LSPACE : PH_IDLE;
              PH_LSPACE: phase_nxt = tok.ls_ok ? PH_MARK : PH_IDLE;
              PH_MARK:   phase_nxt = tok.mark_ok ? PH_SPACE : PH_IDLE;
              PH_SPACE: begin
                if (!tok.space_ok || cnt_r >= CNT_W'(CODE_BITS)) begin
                  phase_nxt = PH_IDLE;
                end else begin
                  code_nxt = {code_r[CODE_BITS-2:0], tok.bit_one};
                  cnt_nxt  = cnt_r + 1'b1;
                  if (cnt_r == CNT_W'(CODE_BITS - 1)) begin
                    ready_nxt = 1'b1;
                  end else begin
                    phase_nxt = PH_MARK;
                  end
                end
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
        ACT_OVF: phase_nxt = PH_IDLE;
        ACT_FETCH: begin
          if (ready_r) begin
            res.code_valid = 1'b1;
            res.command    = upper;
            ready_nxt      = 1'b0;
            phase_nxt      = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    res.busy = (phase_nxt != PH_IDLE) && !ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

`ifndef SYNTH
  a_ready_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (cnt_r == CNT_W'(CODE_BITS)))
    else $error("frame ready without a full bit count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CODE_BITS))
    else $error("bit count beyond code width");

  a_fetch_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && tok.act == ACT_FETCH && ready_r) |=> (!ready_r && phase_r == PH_IDLE))
    else $error("fetch of a ready frame did not rearm the receiver");

  a_valid_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.code_valid) |-> ready_r)
    else $error("code delivered without a completed frame");
`endif

endmodule

[rtl/nec_ir_frame_decoder_core.sv]
`timescale 1ns / 1ps

// Channel  | Ports                                   | Transfer when
// ---------+-----------------------------------------+----------------------------
// input    | push, full, in_action, in_interval      | push && !full
// result   | pop, empty, out_code_valid,             | pop && !empty
//          | out_command, out_busy_res               |
// config   | psel, penable, pwrite, paddr, pwdata,   | psel && penable && pwrite
//          | prdata, pready                          |
//
// One item per clock is sustained while the result queue has room; every item yields exactly one result.
// An input item is registered in the token queue; the back end takes it from
// there when the result queue has room and writes its result into the result
// queue, whose head drives the result ports.
// Reset is synchronous on rst_n low; it loads the register defaults and idles
// the receiver. Both two-entry queues let either side stall independently;
// full rises only when the result side has stalled long enough to back up.

module nec_ir_frame_decoder_core #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     in_action,
  input  logic [nir_pkg::IVL_W-1:0]      in_interval,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_code_valid,
  output logic [nir_pkg::CMD_W-1:0]      out_command,
  output logic                           out_busy_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nir_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nir_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nir_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import nir_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t                   cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [REG_W-1:0]       rd_val;
  logic                   cfg_wr;
  token_t                 tok_in, tok_out;
  logic                   tok_empty, tok_pop;
  logic                   res_full, res_push;
  res_t                   res_in, res_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    rd_val  = '0;
    unique case (reg_idx)
      REG_LP_MIN:   rd_val = cfg_r.lp_min;
      REG_LP_MAX:   rd_val = cfg_r.lp_max;
      REG_LS_MIN:   rd_val = cfg_r.ls_min;
      REG_LS_MAX:   rd_val = cfg_r.ls_max;
      REG_MARK_MIN: rd_val = cfg_r.mark_min;
      REG_MARK_MAX: rd_val = cfg_r.mark_max;
      REG_SPC_MAX:  rd_val = cfg_r.space_max;
      REG_ONE_THR:  rd_val = cfg_r.one_thr;
      default:      rd_val = '0;
    endcase
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_LP_MIN:   cfg_nxt.lp_min    = pwdata[REG_W-1:0];
        REG_LP_MAX:   cfg_nxt.lp_max    = pwdata[REG_W-1:0];
        REG_LS_MIN:   cfg_nxt.ls_min    = pwdata[REG_W-1:0];
        REG_LS_MAX:   cfg_nxt.ls_max    = pwdata[REG_W-1:0];
        REG_MARK_MIN: cfg_nxt.mark_min  = pwdata[REG_W-1:0];
        REG_MARK_MAX: cfg_nxt.mark_max  = pwdata[REG_W-1:0];
        REG_SPC_MAX:  cfg_nxt.space_max = pwdata[REG_W-1:0];
        REG_ONE_THR:  cfg_nxt.one_thr   = pwdata[REG_W-1:0];
        default:      ;
      endcase
    end
  end

  assign prdata = {{(APB_DATA_W - REG_W){1'b0}}, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lp_min    <= RST_LP_MIN;
      cfg_r.lp_max    <= RST_LP_MAX;
      cfg_r.ls_min    <= RST_LS_MIN;
      cfg_r.ls_max    <= RST_LS_MAX;
      cfg_r.mark_min  <= RST_MARK_MIN;
      cfg_r.mark_max  <= RST_MARK_MAX;
      cfg_r.space_max <= RST_SPC_MAX;
      cfg_r.one_thr   <= RST_ONE_THR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nir_front u_front (
    .in_action   (in_action),
    .in_interval (in_interval),
    .cfg         (cfg_r),
    .tok         (tok_in)
  );

  nir_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .dout  (tok_out),
    .empty (tok_empty)
  );

  nir_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tok_empty),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  nir_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_code_valid = res_out.code_valid;
  assign out_command    = res_out.command;
  assign out_busy_res   = res_out.busy;

endmodule

[test/nec_ir_decode_monitor.sv]
`timescale 1ns / 1ps

module nec_ir_decode_monitor #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [1:0]                     in_action,
  input  logic [nir_pkg::IVL_W-1:0]      in_interval,
  input  logic                           pop,
  input  logic                           empty,
  input  logic                           out_code_valid,
  input  logic [nir_pkg::CMD_W-1:0]      out_command,
  input  logic                           out_busy_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [nir_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nir_pkg::APB_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen,
  output int                             codes_seen
);
  import nir_pkg::*;

  cfg_t                 win;
  phase_t               rx_phase;
  logic [6:0]           rx_bits;
  logic [CODE_BITS-1:0] rx_code;
  logic                 rx_ready;

  res_t expected_results[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    codes_seen   = 0;
  end

  // Advances the decoder copy by one item and returns the result it produces.
  function automatic res_t decode_step(logic [1:0] act, logic [IVL_W-1:0] ivl);
    res_t r;
    r = '0;
    case (act)
      ACT_EDGE: begin
        if (!rx_ready) begin
          case (rx_phase)
            PH_IDLE: begin
              rx_phase = PH_LPULSE;
              rx_bits  = '0;
            end
            PH_LPULSE:
              rx_phase = (ivl >= win.lp_min && ivl <= win.lp_max) ? PH_LSPACE : PH_IDLE;
            PH_LSPACE:
              rx_phase = (ivl >= win.ls_min && ivl <= win.ls_max) ? PH_MARK : PH_IDLE;
            PH_MARK:
              rx_phase = (ivl >= win.mark_min && ivl <= win.mark_max) ? PH_SPACE : PH_IDLE;
            PH_SPACE: begin
              if (!(ivl >= win.mark_min && ivl <= win.space_max) || rx_bits >= CODE_BITS) begin
                rx_phase = PH_IDLE;
              end else begin
                rx_code[CODE_BITS - 1 - rx_bits] = (ivl > win.one_thr);
                rx_bits = rx_bits + 7'd1;
                // On the last bit the phase is left as it is; ready masks it.
                if (rx_bits >= CODE_BITS) rx_ready = 1'b1;
                else rx_phase = PH_MARK;
              end
            end
            default: rx_phase = PH_IDLE;
          endcase
        end
      end
      ACT_OVF: rx_phase = PH_IDLE;
      ACT_FETCH: begin
        if (rx_ready) begin
          r.code_valid = 1'b1;
          r.command    = rx_code[CODE_BITS-1 -: CMD_W];
          rx_ready     = 1'b0;
          rx_phase     = PH_IDLE;
        end
      end
      default: ;
    endcase
    r.busy = (rx_phase != PH_IDLE) && !rx_ready;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      win.lp_min    = RST_LP_MIN;
      win.lp_max    = RST_LP_MAX;
      win.ls_min    = RST_LS_MIN;
      win.ls_max    = RST_LS_MAX;
      win.mark_min  = RST_MARK_MIN;
      win.mark_max  = RST_MARK_MAX;
      win.space_max = RST_SPC_MAX;
      win.one_thr   = RST_ONE_THR;
      rx_phase = PH_IDLE;
      rx_bits  = '0;
      rx_code  = '0;
      rx_ready = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_LP_MIN:   win.lp_min    = pwdata[REG_W-1:0];
          REG_LP_MAX:   win.lp_max    = pwdata[REG_W-1:0];
          REG_LS_MIN:   win.ls_min    = pwdata[REG_W-1:0];
          REG_LS_MAX:   win.ls_max    = pwdata[REG_W-1:0];
          REG_MARK_MIN: win.mark_min  = pwdata[REG_W-1:0];
          REG_MARK_MAX: win.mark_max  = pwdata[REG_W-1:0];
          REG_SPC_MAX:  win.space_max = pwdata[REG_W-1:0];
          REG_ONE_THR:  win.one_thr   = pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      // A result transfer always belongs to an older item, so it is checked first.
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_code_valid !== want.code_valid) begin
            $error("code_valid: expected %0d, got %0d", want.code_valid, out_code_valid);
            fail_count++;
          end
          if (out_command !== want.command) begin
            $error("command: expected 0x%04h, got 0x%04h", want.command, out_command);
            fail_count++;
          end
          if (out_busy_res !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, out_busy_res);
            fail_count++;
          end
          if (want.code_valid) codes_seen++;
        end
      end
      if (push && !full) expected_results.push_back(decode_step(in_action, in_interval));
    end
    pending = expected_results.size();
  end

endmodule

[test/tb_nec_ir_frame_decoder_core.sv]
`timescale 1ns / 1ps

module tb_nec_ir_frame_decoder_core;
  import nir_pkg::*;

  localparam int RAND_ITEMS  = 1750;
  localparam int RECV_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    CFG_DEFAULT,
    CFG_WIDE,
    CFG_TIGHT,
    CFG_THR_LOW,
    CFG_THR_HIGH,
    CFG_EMPTY,
    CFG_RANDOM
  } cfg_plan_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  push        = 1'b0;
  logic [1:0]            in_action   = '0;
  logic [IVL_W-1:0]      in_interval = '0;
  logic                  pop         = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  full;
  logic                  empty;
  logic                  out_code_valid;
  logic [CMD_W-1:0]      out_command;
  logic                  out_busy_res;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_seen;
  int codes_seen;

  int   items_sent     = 0;
  int   settings_used  = 0;
  int   stall_requests = 0;
  bit   sender_no_idle = 1'b0;
  cfg_t cur_cfg;

  nec_ir_frame_decoder_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_interval    (in_interval),
    .empty          (empty),
    .pop            (pop),
    .out_code_valid (out_code_valid),
    .out_command    (out_command),
    .out_busy_res   (out_busy_res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  nec_ir_decode_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_interval    (in_interval),
    .pop            (pop),
    .empty          (empty),
    .out_code_valid (out_code_valid),
    .out_command    (out_command),
    .out_busy_res   (out_busy_res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .codes_seen     (codes_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Result side: random pops, runs without gaps, and long holds on request.
  initial begin : result_sink
    int gap;
    int run_left;
    int served;
    bit recv_no_idle;
    run_left     = 0;
    served       = 0;
    recv_no_idle = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (run_left == 0) begin
        recv_no_idle = ($urandom_range(3, 0) == 0);
        run_left     = $urandom_range(60, 10);
      end
      run_left--;
      if (served != stall_requests) begin
        served = stall_requests;
        pop <= 1'b0;
        repeat (RECV_HOLD) @(negedge clk);
      end else begin
        gap = recv_no_idle ? 0 : $urandom_range(3, 0);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] act, input logic [IVL_W-1:0] ivl);
    int gap;
    gap = sender_no_idle ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    in_action   <= act;
    in_interval <= ivl;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Bits above the register width are don't-care and get random filler.
    pwdata  <= {24'($urandom()), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] pick_in(int lo, int hi);
    int a;
    int b;
    a = (lo < 0) ? 0 : lo;
    b = (hi > 255) ? 255 : hi;
    if (a > b) return 8'($urandom_range(255, 0));
    return 8'($urandom_range(b, a));
  endfunction

  function automatic logic [REG_W-1:0] pick_out(int lo, int hi);
    if (lo > 0 && (hi >= 255 || $urandom_range(1, 0) == 1)) return 8'($urandom_range(lo - 1, 0));
    if (hi < 255) return 8'($urandom_range(255, hi + 1));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic void sorted_pair(output logic [REG_W-1:0] lo, output logic [REG_W-1:0] hi);
    logic [REG_W-1:0] a;
    logic [REG_W-1:0] b;
    a  = 8'($urandom_range(255, 0));
    b  = 8'($urandom_range(255, 0));
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
  endfunction

  task automatic set_config(input cfg_plan_t plan);
    cfg_t nc;
    nc = '{RST_LP_MIN, RST_LP_MAX, RST_LS_MIN, RST_LS_MAX,
           RST_MARK_MIN, RST_MARK_MAX, RST_SPC_MAX, RST_ONE_THR};
    case (plan)
      CFG_WIDE: begin
        nc = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'($urandom_range(255, 0))};
      end
      CFG_TIGHT: begin
        nc.lp_min    = 8'($urandom_range(255, 0));
        nc.lp_max    = nc.lp_min;
        nc.ls_min    = 8'($urandom_range(255, 0));
        nc.ls_max    = nc.ls_min;
        nc.mark_min  = 8'($urandom_range(40, 0));
        nc.mark_max  = nc.mark_min;
        nc.space_max = nc.mark_min + 8'($urandom_range(30, 0));
        nc.one_thr   = pick_in(nc.mark_min, nc.space_max);
      end
      CFG_THR_LOW: begin
        nc.mark_min  = 8'd0;
        nc.mark_max  = 8'd255;
        nc.space_max = 8'd255;
        nc.one_thr   = 8'd0;
      end
      CFG_THR_HIGH: begin
        nc = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      end
      CFG_EMPTY: begin
        sorted_pair(nc.lp_max, nc.lp_min);
        sorted_pair(nc.ls_min, nc.ls_max);
        if ($urandom_range(1, 0) == 1) sorted_pair(nc.mark_max, nc.mark_min);
        else sorted_pair(nc.space_max, nc.mark_min);
        nc.one_thr = 8'($urandom_range(255, 0));
      end
      CFG_RANDOM: begin
        sorted_pair(nc.lp_min, nc.lp_max);
        sorted_pair(nc.ls_min, nc.ls_max);
        sorted_pair(nc.mark_min, nc.mark_max);
        nc.space_max = pick_in(nc.mark_min, 255);
        nc.one_thr   = pick_in(nc.mark_min, nc.space_max);
      end
      default: ;
    endcase
    cfg_write(REG_LP_MIN,   nc.lp_min);
    cfg_write(REG_LP_MAX,   nc.lp_max);
    cfg_write(REG_LS_MIN,   nc.ls_min);
    cfg_write(REG_LS_MAX,   nc.ls_max);
    cfg_write(REG_MARK_MIN, nc.mark_min);
    cfg_write(REG_MARK_MAX, nc.mark_max);
    cfg_write(REG_SPC_MAX,  nc.space_max);
    cfg_write(REG_ONE_THR,  nc.one_thr);
    cur_cfg = nc;
    settings_used++;
  endtask

  // Steps of a frame: 0 start edge, 1 leader pulse, 2 leader space, then odd
  // steps are bit marks and even steps bit spaces. At step cut the sender sends
  // instead an out-of-window interval, an overflow or a fetch, and abandons the frame.
  task automatic send_frame(input int cut);
    int s;
    int lo;
    int hi;
    for (s = 0; s < 67; s++) begin
      lo = 0;
      hi = 255;
      if (s == 1) begin
        lo = cur_cfg.lp_min;
        hi = cur_cfg.lp_max;
      end else if (s == 2) begin
        lo = cur_cfg.ls_min;
        hi = cur_cfg.ls_max;
      end else if (s >= 3 && (s % 2) == 1) begin
        lo = cur_cfg.mark_min;
        hi = cur_cfg.mark_max;
      end else if (s >= 4) begin
        lo = cur_cfg.mark_min;
        hi = cur_cfg.space_max;
      end
      if (s == cut) begin
        case ($urandom_range(2, 0))
          0:       send_item(ACT_EDGE, pick_out(lo, hi));
          1:       send_item(ACT_OVF, 8'($urandom_range(255, 0)));
          default: send_item(ACT_FETCH, 8'($urandom_range(255, 0)));
        endcase
        return;
      end
      if (s >= 4 && (s % 2) == 0) begin
        if ($urandom_range(1, 0) == 1) begin
          send_item(ACT_EDGE, pick_in((lo > cur_cfg.one_thr + 1) ? lo : cur_cfg.one_thr + 1, hi));
        end else begin
          send_item(ACT_EDGE, pick_in(lo, (hi < cur_cfg.one_thr) ? hi : cur_cfg.one_thr));
        end
      end else begin
        send_item(ACT_EDGE, pick_in(lo, hi));
      end
    end
  endtask

  initial begin : stimulus
    cfg_plan_t plan[7];
    int ph;
    int phase_end;
    int pick;
    int n;
    plan = '{CFG_WIDE, CFG_TIGHT, CFG_THR_LOW, CFG_THR_HIGH, CFG_EMPTY, CFG_RANDOM, CFG_DEFAULT};
    cur_cfg = '{RST_LP_MIN, RST_LP_MAX, RST_LS_MIN, RST_LS_MAX,
                RST_MARK_MIN, RST_MARK_MAX, RST_SPC_MAX, RST_ONE_THR};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset windows: boundaries of the leader and mark windows and the one threshold.
    send_item(ACT_FETCH, 8'd0);
    send_item(2'd3, 8'd255);
    send_item(ACT_OVF, 8'd0);
    send_item(ACT_EDGE, 8'd0);
    send_item(ACT_EDGE, 8'd131);
    send_item(ACT_EDGE, 8'd255);
    send_item(ACT_EDGE, 8'd149);
    send_item(ACT_EDGE, 8'd7);
    send_item(ACT_EDGE, 8'd132);
    send_item(ACT_EDGE, 8'd61);
    send_item(ACT_EDGE, 8'd0);
    send_item(ACT_EDGE, 8'd148);
    send_item(ACT_EDGE, 8'd79);
    send_item(ACT_EDGE, 8'd1);
    send_item(ACT_EDGE, 8'd140);
    send_item(ACT_EDGE, 8'd62);
    send_item(ACT_EDGE, 8'd5);
    send_item(ACT_EDGE, 8'd2);
    send_item(ACT_EDGE, 8'd140);
    send_item(ACT_EDGE, 8'd78);
    send_item(ACT_EDGE, 8'd6);
    send_item(ACT_EDGE, 8'd16);
    send_item(ACT_EDGE, 8'd10);
    send_item(ACT_EDGE, 8'd15);
    send_item(ACT_EDGE, 8'd11);

    for (ph = 0; ph < 7; ph++) begin
      drain();
      set_config(plan[ph]);
      if (ph == 0) begin
        // Hold the result side and keep offering items so the block backs up.
        stall_requests++;
        sender_no_idle = 1'b1;
        repeat (30) send_item(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
        sender_no_idle = 1'b0;
      end
      phase_end = items_sent + RAND_ITEMS / 7;
      while (items_sent < phase_end) begin
        sender_no_idle = ($urandom_range(4, 0) == 0);
        pick = $urandom_range(9, 0);
        if (pick < 6) begin
          if ($urandom_range(4, 0) != 0) send_item(ACT_OVF, 8'($urandom_range(255, 0)));
          send_frame(-1);
          // A ready frame ignores edges and keeps its code across an overflow.
          if ($urandom_range(2, 0) == 0) begin
            n = $urandom_range(3, 1);
            repeat (n) send_item(ACT_EDGE, 8'($urandom_range(255, 0)));
            send_item(ACT_OVF, 8'($urandom_range(255, 0)));
          end
          send_item(ACT_FETCH, 8'($urandom_range(255, 0)));
          if ($urandom_range(3, 0) == 0) send_item(ACT_FETCH, 8'($urandom_range(255, 0)));
        end else if (pick < 8) begin
          if ($urandom_range(1, 0) == 1) send_item(ACT_OVF, 8'($urandom_range(255, 0)));
          send_frame($urandom_range(66, 0));
        end else begin
          n = $urandom_range(8, 1);
          repeat (n) send_item(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
        end
      end
      sender_no_idle = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d items and checked %0d results, %0d of them delivered codes.",
             items_sent, results_seen, codes_seen);
    $display("Register settings applied: %0d, including open, pinned and empty windows.",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
